[hw/rtl/pip_pkg.sv]
`default_nettype none

package pip_pkg;

    // Default geometry of the vertex table and coordinates
    localparam int MAX_VERTICES_DEF = 8;
    localparam int COORD_WIDTH_DEF  = 32;

    // Fixed field widths
    localparam int INDEX_W = 3;
    localparam int COUNT_W = 4;

    // Vertex count after reset
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

    // Request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TEST  = 1'b1;

    // Status of the shared multiply-accumulate unit
    typedef struct packed {
        logic done;     // accumulator holds the final difference this cycle
        logic gt_zero;  // difference is positive
        logic lt_zero;  // difference is negative
    } t_mac_stat;

endpackage

`default_nettype wire

[hw/rtl/pip_ram.sv]
`default_nettype none

module pip_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pip_mac.sv]
`default_nettype none

// Computes sign(L - R) where L = +/-(a0*b0) and R = +/-(a1*b1), with a and b
// unsigned magnitudes of W bits. One HxH multiplier handles the four half
// products of each operand pair, one per cycle; the partial product is
// registered and added on the next cycle.
module pip_mac
    import pip_pkg::*;
#(
    parameter int W = 33
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a0,
    input  wire logic [W-1:0] i_b0,
    input  wire logic         i_sub0,
    input  wire logic [W-1:0] i_a1,
    input  wire logic [W-1:0] i_b1,
    input  wire logic         i_sub1,
    output t_mac_stat         o_stat
);

    localparam int H     = (W + 1) / 2;
    localparam int ACC_W = 2 * W + 1;

    logic [W-1:0]     r_a [2];
    logic [W-1:0]     r_b [2];
    logic [1:0]       r_sub;
    logic [2:0]       r_k;
    logic             r_busy;
    logic [2*H-1:0]   r_pp;
    logic [1:0]       r_pp_sh;
    logic             r_pp_sub;
    logic             r_pp_vld;
    logic             r_done;
    logic [ACC_W-1:0] r_acc;

    logic             sel_p;
    logic [H-1:0]     a_part;
    logic [H-1:0]     b_part;
    logic [ACC_W-1:0] pp_shifted;

    // Pick the operand pair and halves for this step
    always_comb begin
        sel_p  = r_k[2];
        a_part = r_k[1] ? H'(r_a[sel_p] >> H) : r_a[sel_p][H-1:0];
        b_part = r_k[0] ? H'(r_b[sel_p] >> H) : r_b[sel_p][H-1:0];
        pp_shifted = ACC_W'(r_pp) << (H * int'(r_pp_sh));
    end

    // Step through the partial products and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_pp_vld && !r_busy;
            if (i_start) begin
                r_a[0]   <= i_a0;
                r_b[0]   <= i_b0;
                r_a[1]   <= i_a1;
                r_b[1]   <= i_b1;
                r_sub    <= {i_sub1, i_sub0};
                r_k      <= 3'd0;
                r_busy   <= 1'b1;
                r_pp_vld <= 1'b0;
                r_acc    <= '0;
            end else begin
                r_pp_vld <= r_busy;
                if (r_busy) begin
                    r_pp     <= a_part * b_part;
                    r_pp_sh  <= 2'(r_k[1]) + 2'(r_k[0]);
                    r_pp_sub <= r_sub[sel_p];
                    r_k      <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_busy <= 1'b0;
                    end
                end
                if (r_pp_vld) begin
                    r_acc <= r_pp_sub ? r_acc - pp_shifted : r_acc + pp_shifted;
                end
            end
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.lt_zero = r_acc[ACC_W-1];
    assign o_stat.gt_zero = !r_acc[ACC_W-1] && (r_acc != '0);

endmodule

`default_nettype wire

[hw/rtl/point_in_polygon_test.sv]
`default_nettype none

// Crossing-number point-in-polygon test. A kind-0 request writes one vertex
// into the vertex table as it is taken and gives no result. A kind-1
// request walks the edges of the first min(vertex_count, MAX_VERTICES)
// vertices and returns one inside bit. The walk reads one vertex per cycle
// through the single read port of the vertex RAM, except while an edge that
// straddles the point's y holds it in the multiply state: such an edge runs
// an exact cross-multiplication on one shared half-width multiplier, four
// partial products for each of two products.
// The input is not ready while a test is in progress; a finished result waits
// in the output register while the next request is taken.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [COUNT_W-1:0]     i_cfg_vertex_count,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_kind,
    input  wire logic [INDEX_W-1:0]     i_vertex_index,
    input  wire logic [COORD_WIDTH-1:0] i_coord_x,
    input  wire logic [COORD_WIDTH-1:0] i_coord_y,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic                        o_inside_res
);

    localparam int CW     = COORD_WIDTH;
    localparam int W      = CW + 1;
    localparam int ADDR_W = $clog2(MAX_VERTICES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_EDGE,
        S_MUL,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [COUNT_W-1:0] r_vertex_count;
    logic [CW-1:0]     r_px;
    logic [CW-1:0]     r_py;
    logic [CW-1:0]     r_xj;
    logic [CW-1:0]     r_yj;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_last;
    logic              r_dneg;
    logic              r_flag;
    logic              r_out_valid;
    logic              r_inside;

    logic              in_acc;
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [2*CW-1:0]   rd_data;
    logic [ADDR_W-1:0] n_idx;
    logic              cnt_over;
    logic              cnt_zero;
    logic [ADDR_W-1:0] last_idx;
    logic [CW-1:0]     vi_x;
    logic [CW-1:0]     vi_y;
    logic              straddle;
    logic [W-1:0]      d_px;
    logic [W-1:0]      d_y;
    logic [W-1:0]      d_xj;
    logic [W-1:0]      d_py;
    logic              mac_start;
    logic              edge_last;
    logic              left;
    t_mac_stat         mac_stat;

    // Sign-extended difference a - b
    function automatic logic [W-1:0] f_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        f_diff = {a[CW-1], a} - {b[CW-1], b};
    endfunction

    // Magnitude of a signed W-bit value
    function automatic logic [W-1:0] f_abs(input logic [W-1:0] v);
        f_abs = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_inside_res = r_inside;

    // Clamp the vertex count to the table size
    always_comb begin
        cnt_over = 32'(r_vertex_count) > MAX_VERTICES;
        cnt_zero = (r_vertex_count == '0);
        last_idx = cnt_over ? ADDR_W'(MAX_VERTICES - 1) : ADDR_W'(r_vertex_count - 4'd1);
    end

    // Edge evaluation on the current vertex and the previous one
    always_comb begin
        vi_x      = rd_data[2*CW-1:CW];
        vi_y      = rd_data[CW-1:0];
        straddle  = ($signed(r_py) < $signed(vi_y)) != ($signed(r_py) < $signed(r_yj));
        d_px      = f_diff(r_px, vi_x);
        d_y       = f_diff(r_yj, vi_y);
        d_xj      = f_diff(r_xj, vi_x);
        d_py      = f_diff(r_py, vi_y);
        n_idx     = r_idx + ADDR_W'(1);
        edge_last = (r_idx == r_last);
        left      = r_dneg ? mac_stat.gt_zero : mac_stat.lt_zero;
    end

    // Vertex writes, table reads and multiplier start
    always_comb begin
        wr_en     = in_acc && (i_kind == KIND_WRITE) && (32'(i_vertex_index) < MAX_VERTICES);
        rd_en     = 1'b0;
        rd_addr   = n_idx;
        mac_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_en   = in_acc && (i_kind == KIND_TEST) && !cnt_zero;
                rd_addr = last_idx;
            end
            S_FETCH: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_EDGE: begin
                mac_start = straddle;
                rd_en     = !straddle && !edge_last;
            end
            S_MUL: begin
                rd_en = mac_stat.done && !edge_last;
            end
            S_DONE: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= COUNT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_vertex_count;
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_kind == KIND_TEST)) begin
                        r_px    <= i_coord_x;
                        r_py    <= i_coord_y;
                        r_last  <= last_idx;
                        r_flag  <= 1'b0;
                        r_state <= cnt_zero ? S_DONE : S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_xj    <= vi_x;
                    r_yj    <= vi_y;
                    r_idx   <= '0;
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    r_xj   <= vi_x;
                    r_yj   <= vi_y;
                    r_dneg <= d_y[W-1];
                    if (straddle) begin
                        r_state <= S_MUL;
                    end else if (edge_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= n_idx;
                    end
                end
                S_MUL: begin
                    if (mac_stat.done) begin
                        if (left) begin
                            r_flag <= !r_flag;
                        end
                        if (edge_last) begin
                            r_state <= S_DONE;
                        end else begin
                            r_idx   <= n_idx;
                            r_state <= S_EDGE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_inside    <= r_flag;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    pip_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES),
        .ADDR_W(ADDR_W)
    ) u_vtx_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(ADDR_W'(i_vertex_index)),
        .i_wr_data({i_coord_x, i_coord_y}),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // L = (px - xi) * (yj - yi), R = (xj - xi) * (py - yi); unit gives sign(L - R)
    pip_mac #(
        .W(W)
    ) u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mac_start),
        .i_a0   (f_abs(d_px)),
        .i_b0   (f_abs(d_y)),
        .i_sub0 (d_px[W-1] ^ d_y[W-1]),
        .i_a1   (f_abs(d_xj)),
        .i_b1   (f_abs(d_py)),
        .i_sub1 (!(d_xj[W-1] ^ d_py[W-1])),
        .o_stat (mac_stat)
    );

endmodule

`default_nettype wire

[hw/rtl/pip_chk.sv]
`default_nettype none

module pip_chk
    import pip_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_kind,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_inside_res
);

    // A test request occupies the block on the next cycle
    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_kind == KIND_TEST)) |=> !i_in_ready)
        else $error("input still ready after a test request");

    // After a vertex write the input is ready again on the next cycle
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && (i_kind == KIND_WRITE)) |=> i_in_ready)
        else $error("input not ready after a vertex write");

    // A new result appears only at the end of a test
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without a test in progress");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_inside_res)))
        else $error("stalled result dropped or changed");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_kind      (i_kind),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_inside_res(o_inside_res)
);

`default_nettype wire

[dv/tb_point_in_polygon_test.sv]
module tb_point_in_polygon_test;
    import pip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS   = MAX_VERTICES_DEF;
    localparam int ITEM_TARGET = 1770;
    localparam int QUIET_TAIL  = 200;
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] MINV = 32'sh8000_0000;
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;

    typedef struct {
        logic                kind;
        logic [INDEX_W-1:0]  slot;
        logic signed [31:0]  x;
        logic signed [31:0]  y;
    } t_pip_req;

    // DUT ports; the inputs are known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_vertex_count = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind = KIND_WRITE;
    logic [INDEX_W-1:0]   i_vertex_index = '0;
    logic [31:0]          i_coord_x = '0;
    logic [31:0]          i_coord_y = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_inside_res;

    // Shadow of the polygon state
    logic signed [31:0]   vtx_x [NUM_SLOTS];
    logic signed [31:0]   vtx_y [NUM_SLOTS];
    logic [COUNT_W-1:0]   vtx_count = COUNT_RESET;

    t_pip_req             req_q [$];
    logic                 inside_exp_q [$];
    int                   queued_cnt = 0;
    int                   err_cnt = 0;
    int                   cycle_cnt = 0;
    bit                   in_fire = 1'b0;
    bit                   allow_idle = 1'b1;
    int                   in_gap = 0;
    int                   out_stall = 0;

    point_in_polygon_test dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_vertex_count (i_cfg_vertex_count),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_kind             (i_kind),
        .i_vertex_index     (i_vertex_index),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_inside_res       (o_inside_res)
    );

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("point_in_polygon_test test failed");
            $finish;
        end
    end

    // Crossing-number parity over the active edges, exact in 128 bits
    function automatic logic point_inside(input logic signed [31:0] px,
                                          input logic signed [31:0] py);
        int                  n;
        int                  j;
        logic                flag;
        logic                left;
        logic signed [127:0] xi, yi, xj, yj, wx, wy, dy, lhs, rhs;
        n = (vtx_count > NUM_SLOTS) ? NUM_SLOTS : int'(vtx_count);
        flag = 1'b0;
        for (int i = 0; i < n; i++) begin
            j = (i == 0) ? n - 1 : i - 1;
            // Skip edges that do not straddle the point's y
            if ((py < vtx_y[i]) != (py < vtx_y[j])) begin
                xi = vtx_x[i];
                yi = vtx_y[i];
                xj = vtx_x[j];
                yj = vtx_y[j];
                wx = px;
                wy = py;
                dy = yj - yi;
                lhs = (wx - xi) * dy;
                rhs = (xj - xi) * (wy - yi);
                left = (dy < 0) ? (rhs < lhs) : (lhs < rhs);
                if (left) flag = ~flag;
            end
        end
        return flag;
    endfunction

    // Uniform signed value in [-span, span]; span of zero means the full range
    function automatic logic signed [31:0] coord_in(input int unsigned span);
        if (span == 0) return $urandom();
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    function automatic logic signed [31:0] corner_coord();
        case ($urandom_range(0, 3))
            0: return MINV;
            1: return MAXV;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic push_req(input logic kind, input logic [INDEX_W-1:0] slot,
                            input logic signed [31:0] x, input logic signed [31:0] y);
        t_pip_req r;
        r.kind = kind;
        r.slot = slot;
        r.x = x;
        r.y = y;
        req_q.push_back(r);
        queued_cnt++;
    endtask

    // Wait until every request is taken and every result has come back
    task automatic drain_requests();
        while (req_q.size() != 0 || i_in_valid || inside_exp_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_vertex_count <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        vtx_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Request driver: hold each request until taken, with random gaps
    always @(negedge i_clk) begin
        t_pip_req r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (req_q.size() != 0) begin
                r = req_q.pop_front();
                i_in_valid <= 1'b1;
                i_kind <= r.kind;
                i_vertex_index <= r.slot;
                i_coord_x <= r.x;
                i_coord_y <= r.y;
                if (allow_idle && $urandom_range(0, 5) == 0)
                    in_gap <= $urandom_range(1, 13);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result backpressure in random bursts
    always @(negedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            i_out_ready <= 1'b0;
        end else if (allow_idle && $urandom_range(0, 7) == 0) begin
            out_stall <= $urandom_range(0, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: predict on each taken request, check each taken result
    always @(posedge i_clk) begin
        logic want;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                if (i_kind == KIND_WRITE) begin
                    vtx_x[i_vertex_index] = i_coord_x;
                    vtx_y[i_vertex_index] = i_coord_y;
                end else begin
                    inside_exp_q.push_back(point_inside(i_coord_x, i_coord_y));
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (inside_exp_q.size() == 0) begin
                    $error("inside_res: no result expected, actual %0b", o_inside_res);
                    err_cnt++;
                end else begin
                    want = inside_exp_q.pop_front();
                    if (o_inside_res !== want) begin
                        $error("inside_res: expected %0b, actual %0b", want, o_inside_res);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned        span;
        int unsigned        box;
        int                 n_tests;
        int                 base;
        int                 k;
        logic [COUNT_W-1:0] cnt;
        logic signed [31:0] px [NUM_SLOTS];
        logic signed [31:0] py [NUM_SLOTS];
        logic signed [31:0] tx, ty;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Square in slots 0..3, far corners in 4..7; count 3 is a triangle
        write_vertex_count(4'd3);
        push_req(KIND_WRITE, 3'd0, -10 * ONE, -10 * ONE);
        push_req(KIND_WRITE, 3'd1,  10 * ONE, -10 * ONE);
        push_req(KIND_WRITE, 3'd2,  10 * ONE,  10 * ONE);
        push_req(KIND_WRITE, 3'd3, -10 * ONE,  10 * ONE);
        push_req(KIND_WRITE, 3'd4, MAXV, MAXV);
        push_req(KIND_WRITE, 3'd5, MINV, MAXV);
        push_req(KIND_WRITE, 3'd6, MINV, MINV);
        push_req(KIND_WRITE, 3'd7, MAXV, MINV);
        push_req(KIND_TEST, 3'd5,  5 * ONE,  -5 * ONE);
        push_req(KIND_TEST, 3'd2, -5 * ONE,   5 * ONE);
        push_req(KIND_TEST, 3'd7, -10 * ONE, -10 * ONE);
        push_req(KIND_TEST, 3'd0,  32'sd0,   -10 * ONE);
        push_req(KIND_TEST, 3'd1, MINV, MINV);
        push_req(KIND_TEST, 3'd6, MAXV, MAXV);
        drain_requests();

        // Full table with the extreme corners in the walk
        write_vertex_count(4'd8);
        push_req(KIND_TEST, 3'd0, 32'sd0, 32'sd0);
        push_req(KIND_TEST, 3'd3, MINV, 32'sd0);
        push_req(KIND_TEST, 3'd4, MAXV, -32'sd1);
        drain_requests();

        // Degenerate and oversized counts
        write_vertex_count(4'd0);
        push_req(KIND_TEST, 3'd0, 32'sd0, 32'sd0);
        drain_requests();
        write_vertex_count(4'd1);
        push_req(KIND_TEST, 3'd1, -10 * ONE, -10 * ONE);
        drain_requests();
        write_vertex_count(4'd2);
        push_req(KIND_TEST, 3'd2, 32'sd0, -5 * ONE);
        drain_requests();
        write_vertex_count(4'd15);
        push_req(KIND_TEST, 3'd7, 32'sd0, 32'sd0);
        drain_requests();

        // Random polygons, each followed by a batch of point tests
        while (queued_cnt < ITEM_TARGET) begin
            allow_idle = (queued_cnt < ITEM_TARGET - QUIET_TAIL) &&
                         ($urandom_range(0, 4) != 0);
            cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 15))
                                              : COUNT_W'($urandom_range(3, 8));
            write_vertex_count(cnt);
            case ($urandom_range(0, 3))
                0: span = 300;
                1: span = 100 * ONE;
                2: span = 1 << 29;
                default: span = 0;
            endcase
            box = span + span / 4;

            // Rewrite the whole table, starting at a random slot
            base = $urandom_range(0, NUM_SLOTS - 1);
            for (int s = 0; s < NUM_SLOTS; s++) begin
                k = (base + s) % NUM_SLOTS;
                px[k] = coord_in(span);
                py[k] = coord_in(span);
                push_req(KIND_WRITE, INDEX_W'(k), px[k], py[k]);
            end

            n_tests = $urandom_range(15, 40);
            for (int t = 0; t < n_tests; t++) begin
                if ($urandom_range(0, 11) == 0) begin
                    // Stray vertex write in the middle of the tests
                    push_req(KIND_WRITE, INDEX_W'($urandom_range(0, NUM_SLOTS - 1)),
                             coord_in(span), coord_in(span));
                end else begin
                    k = $urandom_range(0, NUM_SLOTS - 1);
                    case ($urandom_range(0, 9))
                        0, 1: begin
                            tx = px[k];
                            ty = py[k];
                        end
                        2: begin
                            tx = coord_in(box);
                            ty = py[k];
                        end
                        3: begin
                            tx = corner_coord();
                            ty = corner_coord();
                        end
                        4: begin
                            tx = $urandom();
                            ty = $urandom();
                        end
                        default: begin
                            tx = coord_in(box);
                            ty = coord_in(box);
                        end
                    endcase
                    push_req(KIND_TEST, INDEX_W'($urandom_range(0, 7)), tx, ty);
                end
            end
            drain_requests();
        end

        if (err_cnt == 0)
            $display("point_in_polygon_test test passed");
        else
            $display("point_in_polygon_test test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/pip_pkg.sv
hw/rtl/pip_ram.sv
hw/rtl/pip_mac.sv
hw/rtl/point_in_polygon_test.sv
hw/rtl/pip_chk.sv
dv/tb_point_in_polygon_test.sv
